// File: rtl/dbt_pkg.sv
package dbt_pkg;

    localparam int MAX_VECTORS    = 1024;
    localparam int IDX_W          = 11;
    localparam int ADDR_W         = 12;
    localparam int TIME_W         = 16;
    localparam int WORD_W         = 16;
    localparam int MST_W          = 16;
    localparam int MS_W           = 8;
    localparam int WORDS_PER_ITEM = 3;

    localparam logic [ADDR_W-1:0] PTR_RESET = ADDR_W'(2);
    localparam logic [9:0]        MS_TO_US  = 10'd1000;
    localparam logic [WORD_W-1:0] STOP_SS   = 16'hFFFF;
    localparam logic [WORD_W-1:0] ERR_SS    = 16'h0001;
    localparam logic [WORD_W-1:0] SAT_WORD  = 16'hFFFF;

    // start item header addresses
    localparam logic [ADDR_W-1:0] HDR_ZERO_ADDR  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] HDR_COUNT_ADDR = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] HDR_V0_ADDR    = ADDR_W'(3);

    // divider: dt in us fits 26 bits, divisor ss*step_quantum fits 24 bits
    localparam int DT_W        = 26;
    localparam int DVS_W       = 24;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_ITER    = DT_W / DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_ITER);

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);

    localparam logic REG_MAX_STEP_TIME = 1'b0;
    localparam logic REG_STEP_QUANTUM  = 1'b1;

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_VECTOR = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [TIME_W-1:0] time_ms;
        logic [WORD_W-1:0] value;
        logic [IDX_W-1:0]  vector_count;
    } in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [WORD_W-1:0] word_data;
        logic              last;
        logic              error;
    } out_t;

    typedef struct packed {
        logic [MST_W-1:0] max_step_time;
        logic [MS_W-1:0]  step_quantum;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_STOP,
        CMD_ERR,
        CMD_NORM
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              odd;
        logic [ADDR_W-1:0] ptr;
        logic [WORD_W-1:0] value;
        logic [TIME_W-1:0] diff;
        logic [IDX_W-1:0]  count;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1,
        S_WAIT1,
        S_MUL2,
        S_DIV2,
        S_WAIT2,
        S_EMIT
    } back_state_t;

endpackage

// File: rtl/dbt_front.sv
module dbt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  dbt_pkg::in_t  req,
    output logic          cmd_valid,
    output dbt_pkg::cmd_t cmd
);
    import dbt_pkg::*;

    logic [TIME_W-1:0] prev_time_reg, prev_time_next;
    logic [IDX_W-1:0]  vector_index_reg, vector_index_next;
    logic [ADDR_W-1:0] word_pointer_reg, word_pointer_next;
    logic              table_full;
    logic              odd;

    assign table_full = (vector_index_reg >= IDX_W'(MAX_VECTORS));
    assign odd        = ~vector_index_reg[0];

    always_comb
    begin
        prev_time_next    = prev_time_reg;
        vector_index_next = vector_index_reg;
        word_pointer_next = word_pointer_reg;
        cmd_valid         = 1'b0;
        cmd.kind          = CMD_START;
        cmd.odd           = odd;
        cmd.ptr           = word_pointer_reg;
        cmd.value         = req.value;
        cmd.diff          = req.time_ms - prev_time_reg;
        cmd.count         = req.vector_count;

        if (accept)
        begin
            if (req.req_type == REQ_START)
            begin
                cmd_valid         = 1'b1;
                prev_time_next    = req.time_ms;
                vector_index_next = '0;
                word_pointer_next = PTR_RESET;
            end
            else if (!table_full)
            begin
                cmd_valid = 1'b1;
                if (req.time_ms == '0)
                    cmd.kind = CMD_STOP;
                else if (req.time_ms <= prev_time_reg)
                    cmd.kind = CMD_ERR;
                else
                    cmd.kind = CMD_NORM;
                prev_time_next    = req.time_ms;
                vector_index_next = vector_index_reg + IDX_W'(1);
                word_pointer_next = word_pointer_reg + (odd ? ADDR_W'(4) : ADDR_W'(2));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg    <= '0;
            vector_index_reg <= '0;
            word_pointer_reg <= PTR_RESET;
        end
        else
        begin
            prev_time_reg    <= prev_time_next;
            vector_index_reg <= vector_index_next;
            word_pointer_reg <= word_pointer_next;
        end
    end

endmodule

// File: rtl/dbt_cmdq.sv
module dbt_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dbt_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output dbt_pkg::cmd_t cmd_out,
    output logic          empty
);
    import dbt_pkg::*;

    cmd_t                  mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign cmd_out = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (CMDQ_PTR_W+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (CMDQ_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= cmd_in;
    end

endmodule

// File: rtl/dbt_div.sv
module dbt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [dbt_pkg::DT_W-1:0]  dividend,
    input  logic [dbt_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [dbt_pkg::DT_W-1:0]  quotient
);
    import dbt_pkg::*;

    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DT_W-1:0]      quo_reg, quo_next;
    logic [DVS_W-1:0]     divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // restoring division, two quotient bits per cycle
    always_comb
    begin
        logic [DVS_W:0] rem_sh;
        rem_sh   = '0;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_sh   = {rem_next, quo_next[DT_W-1]};
            quo_next = {quo_next[DT_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, divisor_reg})
            begin
                rem_sh      = rem_sh - {1'b0, divisor_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = rem_sh[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// File: rtl/dbt_back.sv
module dbt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  dbt_pkg::cfg_t cfg,
    input  logic          cmd_empty,
    input  dbt_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output dbt_pkg::out_t result
);
    import dbt_pkg::*;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [WORD_W-1:0] ss_reg, ss_next;
    logic [WORD_W-1:0] nos_reg, nos_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [1:0]        k_reg, k_next;

    logic              div_start, div_done;
    logic [DT_W-1:0]   div_dividend, div_quotient;
    logic [DVS_W-1:0]  div_divisor;
    logic [DT_W:0]     ss_full;
    logic [MST_W-1:0]  mts;
    logic [MS_W-1:0]   ms;

    out_t                  word;
    logic                  q_wr, q_rd, q_full;
    out_t                  q_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic [OUTQ_PTR_W:0]   q_count_reg, q_count_next;

    // zero registers act as one
    assign mts     = (cfg.max_step_time == '0) ? MST_W'(1) : cfg.max_step_time;
    assign ms      = (cfg.step_quantum == '0) ? MS_W'(1) : cfg.step_quantum;
    assign ss_full = {1'b0, div_quotient} + (DT_W+1)'(1);

    dbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // word select for the three table writes of one command
    always_comb
    begin
        word.error        = (cmd_reg.kind == CMD_ERR);
        word.last         = (k_reg == 2'd2);
        word.word_address = cmd_reg.ptr;
        word.word_data    = nos_reg;
        if (cmd_reg.kind == CMD_START)
        begin
            case (k_reg)
                2'd0:
                begin
                    word.word_address = HDR_ZERO_ADDR;
                    word.word_data    = '0;
                end
                2'd1:
                begin
                    word.word_address = HDR_COUNT_ADDR;
                    word.word_data    = WORD_W'(cmd_reg.count);
                end
                default:
                begin
                    word.word_address = HDR_V0_ADDR;
                    word.word_data    = cmd_reg.value;
                end
            endcase
        end
        else if (cmd_reg.odd)
        begin
            case (k_reg)
                2'd0:
                begin
                    word.word_address = cmd_reg.ptr;
                    word.word_data    = nos_reg;
                end
                2'd1:
                begin
                    word.word_address = cmd_reg.ptr + ADDR_W'(2);
                    word.word_data    = cmd_reg.value;
                end
                default:
                begin
                    word.word_address = cmd_reg.ptr + ADDR_W'(3);
                    word.word_data    = ss_reg;
                end
            endcase
        end
        else
        begin
            case (k_reg)
                2'd0:
                begin
                    word.word_address = cmd_reg.ptr;
                    word.word_data    = ss_reg;
                end
                2'd1:
                begin
                    word.word_address = cmd_reg.ptr + ADDR_W'(1);
                    word.word_data    = nos_reg;
                end
                default:
                begin
                    word.word_address = cmd_reg.ptr + ADDR_W'(3);
                    word.word_data    = cmd_reg.value;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ss_next      = ss_reg;
        nos_next     = nos_reg;
        k_next       = k_reg;
        cmd_pop      = 1'b0;
        div_start    = 1'b0;
        div_dividend = dt_reg;
        div_divisor  = dvs_reg;
        q_wr         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_STOP:
                        begin
                            ss_next    = STOP_SS;
                            nos_next   = '0;
                            state_next = S_EMIT;
                        end
                        CMD_ERR:
                        begin
                            ss_next    = ERR_SS;
                            nos_next   = '0;
                            state_next = S_EMIT;
                        end
                        CMD_NORM:
                            state_next = S_MUL1;
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            end
            S_MUL1:
                state_next = S_DIV1;
            S_DIV1:
            begin
                // ss = (dt - 1) / max_step_time + 1
                div_start    = 1'b1;
                div_dividend = dt_reg - DT_W'(1);
                div_divisor  = DVS_W'(mts);
                state_next   = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (div_done)
                begin
                    ss_next    = (|ss_full[DT_W:WORD_W]) ? SAT_WORD : ss_full[WORD_W-1:0];
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
                state_next = S_DIV2;
            S_DIV2:
            begin
                // nos = dt / (ss * step_quantum)
                div_start  = 1'b1;
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (div_done)
                begin
                    nos_next   = (|div_quotient[DT_W-1:WORD_W]) ? SAT_WORD
                                                               : div_quotient[WORD_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!q_full)
                begin
                    q_wr   = 1'b1;
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'(WORDS_PER_ITEM - 1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ss_reg  <= ss_next;
        nos_reg <= nos_next;
        if (cmd_pop)
            cmd_reg <= cmd;
        if (state_reg == S_MUL1)
            dt_reg <= DT_W'(cmd_reg.diff) * DT_W'(MS_TO_US);
        if (state_reg == S_MUL2)
            dvs_reg <= DVS_W'(ss_reg) * DVS_W'(ms);
    end

    // result queue
    assign q_full = (q_count_reg == (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
    assign empty  = (q_count_reg == '0);
    assign q_rd   = pop && !empty;
    assign result = q_mem[q_rd_ptr_reg];

    always_comb
    begin
        q_count_next = q_count_reg;
        if (q_wr && !q_rd)
            q_count_next = q_count_reg + (OUTQ_PTR_W+1)'(1);
        else if (q_rd && !q_wr)
            q_count_next = q_count_reg - (OUTQ_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (q_wr)
                q_wr_ptr_reg <= q_wr_ptr_reg + OUTQ_PTR_W'(1);
            if (q_rd)
                q_rd_ptr_reg <= q_rd_ptr_reg + OUTQ_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
            q_mem[q_wr_ptr_reg] <= word;
    end

endmodule

// File: rtl/breakpoint_to_step_table_encoder.sv
// breakpoint to step table encoder
//
// requests come in on item/push/full: a start request (req_type 0) writes
// the table header (word 0 = 0, word 1 = vector count, word 3 = V0); each
// vector request writes three words at interleaved addresses holding the
// number of steps, the value and the step size of that breakpoint
// table words leave on result/empty/pop, oldest first, last marking the
// third word of each request; max_step_time and step_quantum are written
// through wr_en/wr_index/wr_data; the user must write them only while no
// request is in flight, as the block does not enforce it; a vector request
// passes the back end in order: taking the command, one multiply for dt in
// us, two 26-bit divisions (load, 13 steps of two quotient bits, done) in a
// shared divider, one multiply for the nos divisor and writing the three
// words, which holds while the result queue is full; stop, error and start
// requests skip the arithmetic and go straight to writing their three words
// the front end passes an accepted request straight into a two-entry command
// queue, so up to two requests queue up while the back end works
// reset clears the queues, sets max_step_time 1000, step_quantum 5 and the
// word pointer to 2; when pop stays low the four-entry result queue fills,
// the back end holds, then the command queue fills and full goes high
module breakpoint_to_step_table_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  dbt_pkg::in_t                     item,
    output logic                             full,
    input  logic                             pop,
    output logic                             empty,
    output dbt_pkg::out_t                    result,
    input  logic                             wr_en,
    input  logic                             wr_index,
    input  logic [dbt_pkg::MST_W-1:0]        wr_data
);
    import dbt_pkg::*;

    logic [MST_W-1:0] max_step_time_reg;
    logic [MS_W-1:0]  step_quantum_reg;
    cfg_t             cfg;

    logic             accept;
    logic             cmd_push;
    cmd_t             cmd_front;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_empty;
    cmd_t             cmd_back;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_time_reg <= MST_W'(1000);
            step_quantum_reg  <= MS_W'(5);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MAX_STEP_TIME: max_step_time_reg <= wr_data;
                REG_STEP_QUANTUM:  step_quantum_reg  <= wr_data[MS_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg.max_step_time = max_step_time_reg;
    assign cfg.step_quantum  = step_quantum_reg;

    // request accepted whenever the command queue has room
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    // front end: classify, keep previous time, index and word pointer
    dbt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (item),
        .cmd_valid (cmd_push),
        .cmd       (cmd_front)
    );

    dbt_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_front),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .cmd_out (cmd_back),
        .empty   (cmd_empty)
    );

    // back end: step arithmetic and table word output
    dbt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_back),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // front never writes into a full command queue
    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command written into full queue");

    // back never takes a command from an empty queue
    a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command read from empty queue");

    // a step_quantum write lands in the register on the next cycle
    a_step_quantum_write : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_index == REG_STEP_QUANTUM)
            |=> (step_quantum_reg == $past(wr_data[MS_W-1:0])))
        else $error("step_quantum write lost");

endmodule
